// ----- sv/sor_pkg.sv -----
// Shared types, widths and constants of the spike outlier removal block.
package sor_pkg;

    localparam int VAL_W      = 32;
    localparam int TIME_W     = 32;
    localparam int FACTOR_W   = 16;
    localparam int PROD_W     = VAL_W + FACTOR_W;
    localparam int JUMP_SHIFT = 8;
    localparam int SEEN_W     = 3;
    localparam int MAX_PUSH   = 3;
    localparam int PUSH_W     = 2;
    localparam int OUTQ_AW_DEF = 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_SPIKE_FACTOR = 1'b0;
    localparam logic [FACTOR_W-1:0]  FACTOR_RESET     = 16'd25600;

    localparam logic [SEEN_W-1:0] SEEN_PREV    = 3'd1;
    localparam logic [SEEN_W-1:0] SEEN_RELEASE = 3'd2;
    localparam logic [SEEN_W-1:0] SEEN_FULL    = 3'd4;

    typedef struct packed {
        logic [TIME_W-1:0]       kept_time;
        logic signed [VAL_W-1:0] kept_value;
        logic                    run_last;
    } t_result;

    typedef struct packed {
        logic [PUSH_W-1:0]          cnt;
        t_result [MAX_PUSH-1:0]     item;
    } t_push;

endpackage

// ----- sv/sor_in_if.sv -----
// Stream interface carrying input samples.
interface sor_in_if import sor_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [TIME_W-1:0]       sample_time;
    logic signed [VAL_W-1:0] sample_value;
    logic                    series_end;

    modport source (output valid, sample_time, sample_value, series_end, input ready);
    modport sink   (input valid, sample_time, sample_value, series_end, output ready);
endinterface

// ----- sv/sor_out_if.sv -----
// Stream interface carrying retained samples.
interface sor_out_if import sor_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [TIME_W-1:0]       kept_time;
    logic signed [VAL_W-1:0] kept_value;
    logic                    run_last;

    modport source (output valid, kept_time, kept_value, run_last, input ready);
    modport sink   (input valid, kept_time, kept_value, run_last, output ready);
endinterface

// ----- sv/sor_cfg.sv -----
// APB register holding the spike threshold factor.
module sor_cfg import sor_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [FACTOR_W-1:0]   o_factor
);

    logic [FACTOR_W-1:0]  r_factor;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= FACTOR_RESET;
        end else if (wr_en && (reg_idx == REG_SPIKE_FACTOR)) begin
            r_factor <= pwdata[FACTOR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_SPIKE_FACTOR: prdata = CFG_DATA_W'(r_factor);
            default:          prdata = '0;
        endcase
    end

    assign o_factor = r_factor;

endmodule

// ----- sv/sor_judge.sv -----
// Input register, sample window and spike decision; emits up to three results per beat.
module sor_judge import sor_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sor_in_if.sink              i_smp,
    input  logic [FACTOR_W-1:0] i_factor,
    input  logic                i_room,
    output t_push               o_push
);

    logic                    r_in_vld;
    logic [TIME_W-1:0]       r_in_time;
    logic signed [VAL_W-1:0] r_in_value;
    logic                    r_in_end;

    // Window: the two held samples plus the differences the spike test needs.
    logic signed [VAL_W-1:0] r_w2;
    logic signed [VAL_W-1:0] r_w3;
    logic [TIME_W-1:0]       r_t0;
    logic [TIME_W-1:0]       r_t1;
    logic [VAL_W-1:0]        r_left;
    logic signed [VAL_W:0]   r_d1;
    logic signed [VAL_W:0]   r_d2;
    logic [SEEN_W-1:0]       r_seen;

    logic                    go;
    logic signed [VAL_W:0]   d_new;
    logic [VAL_W-1:0]        right;
    logic [VAL_W-1:0]        outer;
    logic [VAL_W-1:0]        mag_d1;
    logic [VAL_W-1:0]        mag_d2;
    logic [VAL_W-1:0]        jump;
    logic [PROD_W-1:0]       thresh;
    logic [PROD_W-1:0]       scaled_jump;
    logic                    sign_flip;
    logic                    spike;
    logic                    keep_mid;
    t_push                   n_push;

    function automatic logic [VAL_W-1:0] mag(input logic signed [VAL_W:0] d);
        logic signed [VAL_W:0] neg;
        neg = -d;
        mag = d[VAL_W] ? neg[VAL_W-1:0] : d[VAL_W-1:0];
    endfunction

    assign go          = r_in_vld && i_room;
    assign i_smp.ready = !r_in_vld || i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_smp.ready) begin
            r_in_vld <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_smp.ready) begin
            r_in_time  <= i_smp.sample_time;
            r_in_value <= i_smp.sample_value;
            r_in_end   <= i_smp.series_end;
        end
    end

    assign d_new  = {r_w3[VAL_W-1], r_w3} - {r_in_value[VAL_W-1], r_in_value};
    assign right  = mag(d_new);
    assign outer  = (r_left > right) ? r_left : right;
    assign mag_d1 = mag(r_d1);
    assign mag_d2 = mag(r_d2);
    assign jump   = (mag_d1 > mag_d2) ? mag_d1 : mag_d2;
    assign thresh = PROD_W'(outer) * PROD_W'(i_factor);
    assign scaled_jump = PROD_W'({jump, JUMP_SHIFT'(0)});

    // The middle sample is a spike only if the slope reverses with nonzero steps.
    assign sign_flip = (r_d1[VAL_W] && !r_d2[VAL_W] && (r_d2 != '0)) ||
                       (r_d2[VAL_W] && !r_d1[VAL_W] && (r_d1 != '0));
    assign spike     = sign_flip && (scaled_jump > thresh);
    assign keep_mid  = (r_seen >= SEEN_RELEASE) && !((r_seen >= SEEN_FULL) && spike);

    always_comb begin
        n_push = '0;
        if (go) begin
            if (keep_mid) begin
                n_push.item[n_push.cnt] = '{kept_time: r_t0, kept_value: r_w2, run_last: 1'b0};
                n_push.cnt = n_push.cnt + PUSH_W'(1);
            end
            if (r_in_end) begin
                if (r_seen >= SEEN_PREV) begin
                    n_push.item[n_push.cnt] =
                        '{kept_time: r_t1, kept_value: r_w3, run_last: 1'b0};
                    n_push.cnt = n_push.cnt + PUSH_W'(1);
                end
                n_push.item[n_push.cnt] =
                    '{kept_time: r_in_time, kept_value: r_in_value, run_last: 1'b1};
                n_push.cnt = n_push.cnt + PUSH_W'(1);
            end
        end
    end

    assign o_push = n_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w2   <= '0;
            r_w3   <= '0;
            r_t0   <= '0;
            r_t1   <= '0;
            r_left <= '0;
            r_d1   <= '0;
            r_d2   <= '0;
            r_seen <= '0;
        end else if (go) begin
            if (r_in_end) begin
                r_seen <= '0;
            end else begin
                r_w2   <= r_w3;
                r_w3   <= r_in_value;
                r_t0   <= r_t1;
                r_t1   <= r_in_time;
                r_left <= mag_d1;
                r_d1   <= r_d2;
                r_d2   <= d_new;
                r_seen <= (r_seen < SEEN_FULL) ? r_seen + SEEN_W'(1) : SEEN_FULL;
            end
        end
    end

`ifndef SYNTHESIS
    a_seen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_FULL)
        else $error("series sample count ran past saturation");

    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && r_in_end) |-> (n_push.cnt != '0))
        else $error("series end produced no result");

    a_mid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && !r_in_end) |-> (n_push.cnt == PUSH_W'(0) || n_push.cnt == PUSH_W'(1)))
        else $error("mid-series beat produced more than one result");
`endif

endmodule

// ----- sv/sor_outq.sv -----
// Result queue: takes up to three results a cycle and hands them out one a beat.
module sor_outq import sor_pkg::*; #(
    parameter int AW = OUTQ_AW_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    output logic       o_room,
    sor_out_if.source  o_kept
);

    localparam int DEPTH      = 1 << AW;
    localparam int ROOM_LIMIT = DEPTH - MAX_PUSH;

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [AW:0]     r_count;
    logic            pop;
    logic [AW:0]     level;
    t_result         head;

    assign pop   = o_kept.valid && o_kept.ready;
    assign level = r_count - (AW+1)'(pop);
    // Room for a full series-end burst once this cycle's pop is counted.
    assign o_room = level <= (AW+1)'(ROOM_LIMIT);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_PUSH; k++) begin
            if (k < int'(i_push.cnt)) begin
                r_mem[r_wr + AW'(k)] <= i_push.item[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + AW'(i_push.cnt);
            r_rd    <= r_rd + AW'(pop);
            r_count <= r_count + (AW+1)'(i_push.cnt) - (AW+1)'(pop);
        end
    end

    assign head              = r_mem[r_rd];
    assign o_kept.valid      = r_count != '0;
    assign o_kept.kept_time  = head.kept_time;
    assign o_kept.kept_value = head.kept_value;
    assign o_kept.run_last   = head.run_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(DEPTH))
        else $error("result queue overflowed");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != '0) |-> o_room)
        else $error("results pushed without room in the queue");
`endif

endmodule

// ----- sv/spike_outlier_removal_top.sv -----
// Path: a result is written from the input register into the result queue and leaves from there;
// a sample is released by the second beat after it, or by its series-end beat if that comes sooner.
// Throughput: one sample per cycle while the result queue has room for three results; a series-end
// beat pushes up to three, and the input stalls until the queue, draining one beat a cycle while the
// receiver is ready, has room again. Reset: synchronous, active low; clears the window, the series
// count, the queue and sets the spike factor to 100.0.
module spike_outlier_removal_top import sor_pkg::*; #(
    parameter int OUTQ_AW = OUTQ_AW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sor_in_if.sink                i_smp,
    sor_out_if.source             o_kept,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [FACTOR_W-1:0] factor;
    logic                room;
    t_push               push;

    sor_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_factor (factor)
    );

    sor_judge u_judge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_smp    (i_smp),
        .i_factor (factor),
        .i_room   (room),
        .o_push   (push)
    );

    sor_outq #(
        .AW (OUTQ_AW)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_kept  (o_kept)
    );

endmodule

// ----- verif/spike_outlier_removal_top_test.sv -----
// Self-checking testbench for the spike outlier removal top level.
`timescale 1ns / 100ps

module spike_outlier_removal_top_test;
    import sor_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_BEATS = 8;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    sor_in_if  smp_if();
    sor_out_if kept_if();

    spike_outlier_removal_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_kept  (kept_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    // Filter state mirrored on the testbench side.
    logic signed [VAL_W-1:0]  win_val [4] = '{default: '0};
    logic [TIME_W-1:0]        win_time [2] = '{default: '0};
    logic [SEEN_W-1:0]        seen_n = '0;
    logic [FACTOR_W-1:0]      factor_m = FACTOR_RESET;

    t_result kept_q [$];

    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     fail_n         = 0;
    int     n_sent         = 0;
    longint cycle_n        = 0;

    function automatic longint mag64(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic t_result make_kept(input logic [TIME_W-1:0] t,
                                          input logic signed [VAL_W-1:0] v,
                                          input logic last);
        t_result r;
        r.kept_time  = t;
        r.kept_value = v;
        r.run_last   = last;
        return r;
    endfunction

    // Appends one expected beat to the tail of the expected queue.
    task automatic queue_expected(input t_result r);
        kept_q = {kept_q, r};
    endtask

    // The middle sample is a spike when its two differences flip sign and the larger
    // one, scaled by 256, beats the larger outer difference times the factor.
    function automatic bit spike_here(input logic signed [VAL_W-1:0] cur);
        longint v0, v1, v2, v3, v4, d1, d2, outer, jump;
        v0 = win_val[0];
        v1 = win_val[1];
        v2 = win_val[2];
        v3 = win_val[3];
        v4 = cur;
        d1 = v1 - v2;
        d2 = v2 - v3;
        if (!((d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0)))
            return 1'b0;
        outer = (mag64(v0 - v1) > mag64(v3 - v4)) ? mag64(v0 - v1) : mag64(v3 - v4);
        jump  = (mag64(d1) > mag64(d2)) ? mag64(d1) : mag64(d2);
        return (jump * 256) > (outer * longint'(factor_m));
    endfunction

    task automatic predict_kept(input logic [TIME_W-1:0] t,
                                input logic signed [VAL_W-1:0] v,
                                input logic e);
        bit keep;
        keep = 1'b1;
        if (seen_n >= SEEN_RELEASE) begin
            if (seen_n >= SEEN_FULL)
                keep = !spike_here(v);
            if (keep)
                queue_expected(make_kept(win_time[0], win_val[2], 1'b0));
        end
        if (e) begin
            if (seen_n >= SEEN_PREV)
                queue_expected(make_kept(win_time[1], win_val[3], 1'b0));
            queue_expected(make_kept(t, v, 1'b1));
            seen_n = '0;
        end else begin
            win_val[0]  = win_val[1];
            win_val[1]  = win_val[2];
            win_val[2]  = win_val[3];
            win_val[3]  = v;
            win_time[0] = win_time[1];
            win_time[1] = t;
            seen_n = (seen_n < SEEN_FULL) ? seen_n + SEEN_W'(1) : SEEN_FULL;
        end
    endtask

    // One input beat, preceded by random idle cycles.
    task automatic send_sample(input logic [TIME_W-1:0] t,
                               input logic signed [VAL_W-1:0] v,
                               input logic e);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_if.valid        <= 1'b1;
        smp_if.sample_time  <= t;
        smp_if.sample_value <= v;
        smp_if.series_end   <= e;
        do @(posedge i_clk); while (!smp_if.ready);
        predict_kept(t, v, e);
        n_sent++;
    endtask

    // Holds the sender off until every predicted beat has come out.
    task automatic wait_drained();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (kept_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Used between phases: dropped samples leave nothing in the queue to wait for.
    task automatic settle_idle();
        wait_drained();
        repeat (SETTLE_BEATS) @(posedge i_clk);
    endtask

    task automatic write_spike_factor(input logic [FACTOR_W-1:0] f);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({REG_SPIKE_FACTOR, 2'b00});
        pwdata  <= CFG_DATA_W'(f);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        factor_m = f;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[FACTOR_W-1:0] !== factor_m) begin
            $error("spike_factor: expected %h, actual %h", factor_m, prdata[FACTOR_W-1:0]);
            fail_n++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Series of one to four samples are passed whole.
    task automatic test_short_series();
        logic [TIME_W-1:0] t;
        t = 32'd100;
        for (int len = 1; len <= 4; len++) begin
            for (int i = 0; i < len; i++) begin
                send_sample(t, VAL_W'((len << 16) + i), (i == len - 1));
                t += 32'd10;
            end
        end
        settle_idle();
    endtask

    // Spikes between flat neighbours are dropped whatever the factor; the sender
    // also waits for the queue to empty in the middle of the series.
    task automatic test_flat_spike();
        logic signed [VAL_W-1:0] vals [9];
        vals = '{32'sd0, 32'sd0, 32'sd0, 32'sh0001_0000, 32'sd0, 32'sd0,
                 -32'sh0003_0000, 32'sd0, 32'sd0};
        for (int i = 0; i < 9; i++) begin
            if (i == 5)
                wait_drained();
            send_sample(32'h1000 + i, vals[i], (i == 8));
        end
        settle_idle();
    endtask

    task automatic test_extremes();
        logic [TIME_W-1:0]       tms  [6];
        logic signed [VAL_W-1:0] vals [6];
        tms  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'hAAAA_5555, 32'h5555_AAAA};
        vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 32'sh7FFF_FFFF, 32'sh8000_0000};
        recv_stall_pct = 34;
        for (int i = 0; i < 6; i++)
            send_sample(tms[i], vals[i], (i == 5));
        settle_idle();
    endtask

    // A series of smooth, flat or fully random values, with spikes thrown into all but the random ones.
    task automatic send_series(input int len);
        int                kind, noise, r, base, v;
        logic [TIME_W-1:0] t;
        kind  = $urandom_range(0, 9);
        noise = 16 << (4 * $urandom_range(0, 3));
        base  = $urandom;
        t     = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4096);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (kind < 2)
                v = $urandom;
            else if (r < 15)
                v = base + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1 << 12, 1 << 28);
            else if (kind < 4)
                v = base;
            else
                v = base + $urandom_range(0, noise) - noise / 2;
            if ($urandom_range(0, 19) == 0)
                t = $urandom;
            else
                t += $urandom_range(1, 1000);
            if ($urandom_range(0, 59) == 0)
                wait_drained();
            send_sample(t, v, (i == len - 1));
        end
    endtask

    task automatic test_random(input logic [FACTOR_W-1:0] f, input int idle_pct,
                               input int stall_pct, input int n_items);
        int stop_at;
        write_spike_factor(f);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at)
            send_series(($urandom_range(0, 4) == 0) ? $urandom_range(1, 4)
                                                    : $urandom_range(5, 14));
        settle_idle();
    endtask

    // Result checker and receiver stall generator in one process, so that the
    // ready level it checks against is the one the block saw at this edge.
    always @(posedge i_clk) begin
        if (kept_if.valid && kept_if.ready) begin
            if (kept_q.size() == 0) begin
                $error("unexpected beat: time %h value %h last %b",
                       kept_if.kept_time, kept_if.kept_value, kept_if.run_last);
                fail_n++;
            end else begin
                t_result exp_r;
                exp_r = kept_q.pop_front();
                if (kept_if.kept_time !== exp_r.kept_time) begin
                    $error("kept_time: expected %h, actual %h",
                           exp_r.kept_time, kept_if.kept_time);
                    fail_n++;
                end
                if (kept_if.kept_value !== exp_r.kept_value) begin
                    $error("kept_value: expected %h, actual %h",
                           exp_r.kept_value, kept_if.kept_value);
                    fail_n++;
                end
                if (kept_if.run_last !== exp_r.run_last) begin
                    $error("run_last: expected %b, actual %b",
                           exp_r.run_last, kept_if.run_last);
                    fail_n++;
                end
            end
        end
        kept_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        smp_if.valid        <= 1'b0;
        smp_if.sample_time  <= '0;
        smp_if.sample_value <= '0;
        smp_if.series_end   <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_series();
        test_flat_spike();
        test_extremes();
        test_random(16'd0,     0,  0,  85);
        test_random(16'hFFFF,  86, 0,  85);
        test_random(16'd256,   0,  86, 85);
        test_random(FACTOR_W'($urandom_range(128, 4096)), 34, 34, 85);

        if (fail_n == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/sor_pkg.sv
sv/sor_in_if.sv
sv/sor_out_if.sv
sv/sor_cfg.sv
sv/sor_judge.sv
sv/sor_outq.sv
sv/spike_outlier_removal_top.sv
verif/spike_outlier_removal_top_test.sv
